[src/wrg_pkg.sv]
// ----------------------------------------------------------------------------
// Waypoint roll guidance package
// Types, constants and the arctangent table shared by the guidance block.
// ----------------------------------------------------------------------------
`default_nettype none

package wrg_pkg;

   localparam int CordicSteps = 16;
   localparam int AtanLen     = 24;
   localparam int NumSteps    = (CordicSteps < AtanLen) ? CordicSteps : AtanLen;
   localparam int VelBits     = 16;
   localparam int DivBits     = 20;
   localparam int CntW        = 5;
   localparam int CsrCount    = 8;
   localparam int NumWp       = 4;

   typedef logic signed [24:0] angle_type;

   localparam angle_type AngPi = 25'sd6588397;

   localparam angle_type AtanTab [AtanLen] = '{
      25'sd1647099, 25'sd972340, 25'sd513757, 25'sd260791,
      25'sd130902,  25'sd65515,  25'sd32765,  25'sd16384,
      25'sd8192,    25'sd4096,   25'sd2048,   25'sd1024,
      25'sd512,     25'sd256,    25'sd128,    25'sd64,
      25'sd32,      25'sd16,     25'sd8,      25'sd4,
      25'sd2,       25'sd1,      25'sd0,      25'sd0
   };

   localparam logic signed [30:0] WpLatReset [NumWp] = '{
      31'sd447329130, 31'sd447344640, 31'sd447349590, 31'sd447329280
   };
   localparam logic signed [31:0] WpLonReset [NumWp] = '{
      -32'sd930594000, -32'sd930576970, -32'sd930629000, -32'sd930625000
   };

   localparam logic signed [31:0] KLat       = 32'sd111112;
   localparam logic signed [31:0] KLon       = 32'sd80206;
   localparam logic signed [31:0] KFiltMem   = 32'sd59297;
   localparam logic signed [31:0] KFiltIn    = 32'sd6236;
   localparam logic [60:0]        ReachLimit = 61'd202500000000000000;
   localparam logic [32:0]        FarLat     = 33'd4096;
   localparam logic [32:0]        FarLon     = 33'd8192;
   localparam logic signed [42:0] FiltRound  = 43'sd32768;
   localparam logic signed [26:0] DeltaMax   = 27'sd8388607;
   localparam logic signed [26:0] RollOffset = 27'sd160;
   localparam logic signed [20:0] RollMax    = 21'sd11469;
   localparam logic [3:0]         DivConst   = 4'd5;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_PRE,
      S_NORM,
      S_CORDIC,
      S_FILT1,
      S_FILT2,
      S_DINIT,
      S_DIV,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

[src/waypoint_roll_guidance.sv]
// ----------------------------------------------------------------------------
// Waypoint roll guidance
// Steers toward one of four waypoints: heading error by CORDIC, low-pass
// filtered, scaled and clamped into a roll command.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | latitude, longitude, vel_north, vel_east
//  rsp     | out       | rsp_valid/rsp_stall | roll_command, target_index
//  csr     | in        | csr_wen            | csr_index, csr_wdata
//
// A transaction runs the bit-serial dot and cross products, normalization,
// 16 CORDIC steps and the serial divide; normalization and CORDIC are skipped
// when the offset or velocity is zero. Reset is synchronous. A stalled result
// holds the block.
`default_nettype none

module waypoint_roll_guidance
   import wrg_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [30:0] req_latitude,
   input  wire logic signed [31:0] req_longitude,
   input  wire logic signed [15:0] req_vel_north,
   input  wire logic signed [15:0] req_vel_east,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [14:0]      rsp_roll_command,
   output logic [1:0]              rsp_target_index,
   input  wire logic               csr_wen,
   input  wire logic [3:0]         csr_index,
   input  wire logic [31:0]        csr_wdata
);

   state_type              state_ff, state_in;
   logic [CntW-1:0]        cnt_ff, cnt_in;
   logic [1:0]             idx_ff;
   logic signed [30:0]     wp_lat_ff [NumWp];
   logic signed [31:0]     wp_lon_ff [NumWp];
   logic signed [31:0]     dlat_ff;
   logic signed [32:0]     dlon_ff;
   logic [VelBits-1:0]     vn_ff, ve_ff;
   logic signed [48:0]     dot_ff, cross_ff;
   logic signed [52:0]     x_ff, y_ff;
   angle_type              z_ff;
   logic                   far_ff, zero_ff, neg_ff;
   logic [29:0]            a_ff, b_ff;
   logic [59:0]            sq_ff;
   logic signed [42:0]     filt_ff;
   logic signed [23:0]     mem_ff;
   logic [DivBits-1:0]     div_ff;
   logic [2:0]             rem_ff;
   logic                   rsp_valid_ff;
   logic signed [14:0]     roll_ff;
   logic [1:0]             tidx_ff;

   logic                   accept, load_out, first_bit, cordic_last;
   logic [31:0]            abs_lat;
   logic [32:0]            abs_lon;
   logic signed [31:0]     mul_a, mul_b;
   logic signed [63:0]     mul_p;
   logic signed [48:0]     dlat_x, dlon_x, td, tc;
   logic signed [52:0]     xe, ye, x_sh, y_sh;
   logic [52:0]            ax, ay;
   logic                   small4, small1;
   logic [60:0]            dist_sum;
   logic signed [42:0]     filt_sum;
   logic signed [26:0]     delta_raw, delta_sat, num, num_u;
   logic [3:0]             rem_try;
   logic                   rem_ge;
   logic signed [20:0]     quot, roll_raw, roll_clamp;

   assign accept      = req_valid && !req_stall;
   assign req_stall   = (state_ff != S_IDLE);
   assign load_out    = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign first_bit   = (cnt_ff == '0);
   assign cordic_last = (cnt_ff == CntW'(NumSteps - 1));

   assign abs_lat = dlat_ff[31] ? 32'(-dlat_ff) : 32'(dlat_ff);
   assign abs_lon = dlon_ff[32] ? 33'(-dlon_ff) : 33'(dlon_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      priority if (state_ff == S_MUL && cnt_ff == CntW'(0)) begin
         mul_a = {19'b0, abs_lat[12:0]};
         mul_b = KLat;
      end else if (state_ff == S_MUL && cnt_ff == CntW'(1)) begin
         mul_a = {18'b0, abs_lon[13:0]};
         mul_b = KLon;
      end else if (state_ff == S_MUL && cnt_ff == CntW'(2)) begin
         mul_a = {2'b0, a_ff};
         mul_b = {2'b0, a_ff};
      end else if (state_ff == S_MUL && cnt_ff == CntW'(3)) begin
         mul_a = {2'b0, b_ff};
         mul_b = {2'b0, b_ff};
      end else if (state_ff == S_FILT1) begin
         mul_a = 32'(mem_ff);
         mul_b = KFiltMem;
      end else if (state_ff == S_FILT2) begin
         mul_a = 32'(z_ff);
         mul_b = KFiltIn;
      end else begin
         mul_a = '0;
         mul_b = '0;
      end
   end

   assign mul_p    = mul_a * mul_b;
   assign dist_sum = 61'(sq_ff) + 61'(mul_p[59:0]);

   assign dlat_x = 49'(dlat_ff);
   assign dlon_x = 49'(dlon_ff);
   assign td = (vn_ff[VelBits-1] ? dlat_x : 49'sd0) + (ve_ff[VelBits-1] ? dlon_x : 49'sd0);
   assign tc = (ve_ff[VelBits-1] ? dlat_x : 49'sd0) - (vn_ff[VelBits-1] ? dlon_x : 49'sd0);

   assign xe = 53'(dot_ff);
   assign ye = 53'(cross_ff);
   assign ax = x_ff[52] ? 53'(-x_ff) : 53'(x_ff);
   assign ay = y_ff[52] ? 53'(-y_ff) : 53'(y_ff);
   assign small4 = (ax < (53'd1 << 43)) && (ay < (53'd1 << 43));
   assign small1 = (ax < (53'd1 << 47)) && (ay < (53'd1 << 47));
   assign x_sh = x_ff >>> cnt_ff;
   assign y_sh = y_ff >>> cnt_ff;

   assign filt_sum  = filt_ff + mul_p[42:0] + FiltRound;
   assign delta_raw = 27'(filt_sum >>> 16);
   assign delta_sat = (delta_raw > DeltaMax) ? DeltaMax :
                      (delta_raw < -DeltaMax) ? -DeltaMax : delta_raw;

   assign num   = RollOffset - 27'sd3 * 27'(mem_ff);
   assign num_u = num[26] ? ~num : num;

   assign rem_try = {rem_ff, div_ff[DivBits-1]};
   assign rem_ge  = (rem_try >= DivConst);

   assign quot       = {1'b0, div_ff};
   assign roll_raw   = neg_ff ? ~quot : quot;
   assign roll_clamp = (roll_raw > RollMax) ? RollMax :
                       (roll_raw < -RollMax) ? -RollMax : roll_raw;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_MUL;
               cnt_in   = '0;
            end
         end
         S_MUL: begin
            cnt_in = cnt_ff + CntW'(1);
            if (cnt_ff == CntW'(VelBits - 1)) begin
               state_in = S_PRE;
            end
         end
         S_PRE: begin
            state_in = zero_ff ? S_FILT1 : S_NORM;
         end
         S_NORM: begin
            if (!small1) begin
               state_in = S_CORDIC;
               cnt_in   = '0;
            end
         end
         S_CORDIC: begin
            cnt_in = cnt_ff + CntW'(1);
            if (cordic_last) begin
               state_in = S_FILT1;
            end
         end
         S_FILT1: state_in = S_FILT2;
         S_FILT2: state_in = S_DINIT;
         S_DINIT: begin
            state_in = S_DIV;
            cnt_in   = '0;
         end
         S_DIV: begin
            cnt_in = cnt_ff + CntW'(1);
            if (cnt_ff == CntW'(DivBits - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (load_out) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumWp; i++) begin
            wp_lat_ff[i] <= WpLatReset[i];
            wp_lon_ff[i] <= WpLonReset[i];
         end
      end else if (csr_wen && csr_index < 4'(CsrCount)) begin
         if (csr_index[0]) begin
            wp_lon_ff[csr_index[2:1]] <= csr_wdata;
         end else begin
            wp_lat_ff[csr_index[2:1]] <= csr_wdata[30:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd1;
         mem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_MUL && cnt_ff == CntW'(3) && !far_ff && dist_sum < ReachLimit) begin
            idx_ff <= idx_ff + 2'd1;
         end
         if (state_ff == S_FILT2) begin
            mem_ff <= 24'(delta_sat);
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            dlat_ff  <= 32'(wp_lat_ff[idx_ff]) - 32'(req_latitude);
            dlon_ff  <= 33'(wp_lon_ff[idx_ff]) - 33'(req_longitude);
            vn_ff    <= req_vel_north;
            ve_ff    <= req_vel_east;
            dot_ff   <= '0;
            cross_ff <= '0;
         end
         S_MUL: begin
            dot_ff   <= (dot_ff <<< 1) + (first_bit ? -td : td);
            cross_ff <= (cross_ff <<< 1) + (first_bit ? -tc : tc);
            vn_ff    <= {vn_ff[VelBits-2:0], 1'b0};
            ve_ff    <= {ve_ff[VelBits-2:0], 1'b0};
            if (first_bit) begin
               far_ff  <= (abs_lat > FarLat) || (abs_lon > FarLon);
               zero_ff <= (dlat_ff == '0 && dlon_ff == '0) ||
                          (vn_ff == '0 && ve_ff == '0);
               a_ff    <= mul_p[29:0];
            end
            if (cnt_ff == CntW'(1)) begin
               b_ff <= mul_p[29:0];
            end
            if (cnt_ff == CntW'(2)) begin
               sq_ff <= mul_p[59:0];
            end
         end
         S_PRE: begin
            if (zero_ff) begin
               z_ff <= '0;
            end else if (dot_ff[48]) begin
               x_ff <= -xe;
               y_ff <= -ye;
               z_ff <= cross_ff[48] ? -AngPi : AngPi;
            end else begin
               x_ff <= xe;
               y_ff <= ye;
               z_ff <= '0;
            end
         end
         S_NORM: begin
            if (small4) begin
               x_ff <= x_ff <<< 4;
               y_ff <= y_ff <<< 4;
            end else if (small1) begin
               x_ff <= x_ff <<< 1;
               y_ff <= y_ff <<< 1;
            end
         end
         S_CORDIC: begin
            if (!y_ff[52]) begin
               x_ff <= x_ff + y_sh;
               y_ff <= y_ff - x_sh;
               z_ff <= z_ff + AtanTab[cnt_ff];
            end else begin
               x_ff <= x_ff - y_sh;
               y_ff <= y_ff + x_sh;
               z_ff <= z_ff - AtanTab[cnt_ff];
            end
         end
         S_FILT1: filt_ff <= mul_p[42:0];
         S_FILT2: ;
         S_DINIT: begin
            neg_ff <= num[26];
            div_ff <= num_u[25:6];
            rem_ff <= '0;
         end
         S_DIV: begin
            rem_ff <= rem_ge ? 3'(rem_try - DivConst) : rem_try[2:0];
            div_ff <= {div_ff[DivBits-2:0], rem_ge};
         end
         S_DONE: begin
            if (load_out) begin
               roll_ff <= 15'(roll_clamp);
               tidx_ff <= idx_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_roll_command = roll_ff;
   assign rsp_target_index = tidx_ff;

`ifndef NO_ASSERTIONS
   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(idx_ff)) |-> (idx_ff == $past(idx_ff) + 2'd1))
      else $error("waypoint index moved by other than one");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("result appeared outside the completion state");

   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (roll_ff <= 15'sd11469 && roll_ff >= -15'sd11469))
      else $error("roll command outside its clamp");

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CORDIC || state_ff == S_DIV) |=> (state_ff != S_MUL))
      else $error("new transaction started during computation");
`endif

endmodule

`default_nettype wire
